### rtl/lj_pair_energy_cutoff_shift_unit_assert.svh
// Assertion macros shared by the pair energy unit
`ifndef LJ_PAIR_ENERGY_CUTOFF_SHIFT_UNIT_ASSERT_SVH
`define LJ_PAIR_ENERGY_CUTOFF_SHIFT_UNIT_ASSERT_SVH

// condition and consequence in the same cycle
`define LJPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pair energy unit: assertion failed");

// consequence in the cycle after the condition
`define LJPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pair energy unit: assertion failed");

`endif

### rtl/ljpe_pkg.sv
// Types, constants and step functions of the pair energy unit
package ljpe_pkg;

    localparam int SEP_W      = 24;
    localparam int R_W        = 48;
    localparam int Q_W        = 64;
    localparam int P_W        = 20;
    localparam int C_W        = 23;
    localparam int WIDX_W     = 2;
    localparam int NUM_WORDS  = 3;
    localparam int TERM_W     = 64;
    localparam int DIV_STEPS  = 64;
    localparam int FIFO_DEPTH = 4;
    localparam int K_CAL      = 12;
    localparam int K_PAIR     = 36;

    localparam logic [WIDX_W-1:0] CFG_FIRST_FIRST   = 2'd0;
    localparam logic [WIDX_W-1:0] CFG_FIRST_SECOND  = 2'd1;
    localparam logic [WIDX_W-1:0] CFG_SECOND_SECOND = 2'd2;

    localparam logic [Q_W-1:0]           ONE_Q32  = 64'h0000_0001_0000_0000;
    localparam logic signed [TERM_W-1:0] TERM_LIM = 64'sh4000_0000_0000_0000;
    localparam logic signed [31:0]       E_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]       E_MIN    = 32'sh8000_0000;

    typedef struct packed {
        logic signed [SEP_W-1:0] sep_x;
        logic signed [SEP_W-1:0] sep_y;
        logic signed [SEP_W-1:0] sep_z;
        logic                    kind_a;
        logic                    kind_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pair_energy;
        logic               saturated;
    } t_out;

    // one request in the back end; lo holds the dividend bits and collects the quotient
    typedef struct packed {
        logic              cal;
        logic [WIDX_W-1:0] widx;
        logic              shift;
        logic [P_W-1:0]    p;
        logic              zero;
        logic              far;
        logic              clip;
        logic [R_W-1:0]    den;
        logic [R_W-1:0]    rem;
        logic [Q_W-1:0]    lo;
    } t_bk;

    // one restoring division step
    function automatic t_bk f_div_step(input t_bk a);
        t_bk          b;
        logic [R_W:0] acc;
        logic         qb;
        acc = {a.rem, a.lo[Q_W-1]};
        qb  = (acc >= {1'b0, a.den});
        if (qb) begin
            acc = acc - {1'b0, a.den};
        end
        b     = a;
        b.rem = acc[R_W-1:0];
        b.lo  = {a.lo[Q_W-2:0], qb};
        return b;
    endfunction

    // set up the next division: quotient times 2^k over the same divisor
    function automatic t_bk f_prep(input t_bk a);
        t_bk            b;
        logic [R_W-1:0] r0;
        b = a;
        if (a.cal) begin
            r0   = R_W'(a.lo[Q_W-1:Q_W-K_CAL]);
            b.lo = {a.lo[Q_W-K_CAL-1:0], {K_CAL{1'b0}}};
        end else begin
            r0   = R_W'(a.lo[Q_W-1:Q_W-K_PAIR]);
            b.lo = {a.lo[Q_W-K_PAIR-1:0], {K_PAIR{1'b0}}};
        end
        b.rem  = r0;
        // quotient would reach 2^64
        b.clip = a.clip | (r0 >= a.den);
        return b;
    endfunction

endpackage

### rtl/ljpe_front.sv
// Front end: pair words, input acceptance, squared distance and classification
module ljpe_front
    import ljpe_pkg::*;
#(
    parameter int NUM_TYPES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIDX_W-1:0] i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    input  logic              i_push_ok,
    output logic              o_push,
    output t_bk               o_item
);

    logic [63:0]          r_word [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_pend, n_pend;

    logic              r_f1_v, r_f1_cal;
    logic [WIDX_W-1:0] r_f1_widx;
    logic [63:0]       r_f1_word;
    logic [SEP_W-1:0]  r_f1_ax, r_f1_ay, r_f1_az;

    logic                r_f2_v, r_f2_cal;
    logic [WIDX_W-1:0]   r_f2_widx;
    logic [63:0]         r_f2_word;
    logic [2*SEP_W-1:0]  r_f2_sx, r_f2_sy, r_f2_sz;

    logic              w_en, w_cal_go, w_acc, w_cfg_hit, w_ka, w_kb;
    logic [WIDX_W-1:0] w_cal_idx, w_kind_idx, w_sel;
    logic [R_W-1:0]    w_r2;
    logic [C_W-1:0]    w_c;

    function automatic logic [SEP_W-1:0] f_mag(input logic signed [SEP_W-1:0] v);
        return v[SEP_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_en       = !r_f2_v || i_push_ok;
    assign w_cal_go   = w_en && (r_pend != '0);
    assign o_in_ready = w_en && (r_pend == '0);
    assign w_acc      = i_in_valid && o_in_ready;

    // types beyond the range fold onto the last type
    assign w_ka       = (NUM_TYPES > 1) ? i_in_data.kind_a : 1'b0;
    assign w_kb       = (NUM_TYPES > 1) ? i_in_data.kind_b : 1'b0;
    assign w_kind_idx = {1'b0, w_ka} + {1'b0, w_kb};

    always_comb begin
        if (r_pend[0]) begin
            w_cal_idx = CFG_FIRST_FIRST;
        end else if (r_pend[1]) begin
            w_cal_idx = CFG_FIRST_SECOND;
        end else begin
            w_cal_idx = CFG_SECOND_SECOND;
        end
    end

    assign w_sel = w_cal_go ? w_cal_idx : w_kind_idx;

    always_comb begin
        case (i_cfg_idx)
            CFG_FIRST_FIRST, CFG_FIRST_SECOND, CFG_SECOND_SECOND: w_cfg_hit = i_cfg_we;
            default: w_cfg_hit = 1'b0;
        endcase
    end

    // a written pair word gets its cutoff term recomputed through the back end
    always_comb begin
        n_pend = r_pend;
        if (w_cal_go) begin
            n_pend = n_pend & ~(3'b001 << w_cal_idx);
        end
        if (w_cfg_hit) begin
            n_pend = n_pend | (3'b001 << i_cfg_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_word[i] <= '0;
            end
        end else begin
            r_pend <= n_pend;
            if (w_cfg_hit) begin
                r_word[i_cfg_idx] <= i_cfg_data;
            end
            if (w_en) begin
                r_f1_v <= w_acc || w_cal_go;
                r_f2_v <= r_f1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_cal  <= w_cal_go;
            r_f1_widx <= w_sel;
            r_f1_word <= r_word[w_sel];
            r_f1_ax   <= f_mag(i_in_data.sep_x);
            r_f1_ay   <= f_mag(i_in_data.sep_y);
            r_f1_az   <= f_mag(i_in_data.sep_z);
            r_f2_cal  <= r_f1_cal;
            r_f2_widx <= r_f1_widx;
            r_f2_word <= r_f1_word;
            r_f2_sx   <= (2*SEP_W)'(r_f1_ax) * (2*SEP_W)'(r_f1_ax);
            r_f2_sy   <= (2*SEP_W)'(r_f1_ay) * (2*SEP_W)'(r_f1_ay);
            r_f2_sz   <= (2*SEP_W)'(r_f1_az) * (2*SEP_W)'(r_f1_az);
        end
    end

    assign w_r2 = R_W'(r_f2_sx) + R_W'(r_f2_sy) + R_W'(r_f2_sz);
    assign w_c  = r_f2_word[62:40];

    always_comb begin
        o_item       = '0;
        o_item.cal   = r_f2_cal;
        o_item.widx  = r_f2_widx;
        o_item.shift = r_f2_word[63];
        o_item.p     = r_f2_word[19:0];
        o_item.zero  = (w_r2 == '0);
        o_item.far   = w_r2 > R_W'({w_c, 16'h0000});
        o_item.clip  = 1'b0;
        o_item.den   = r_f2_cal ? R_W'(w_c) : w_r2;
        o_item.rem   = '0;
        o_item.lo    = {r_f2_word[39:20], 44'h0};
    end

    assign o_push = r_f2_v && i_push_ok;

endmodule

### rtl/ljpe_fifo.sv
// Short request queue between front and back end
module ljpe_fifo
    import ljpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_bk  i_item,
    input  logic i_pop,
    output t_bk  o_item,
    output logic o_empty,
    output logic o_full,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH+1);

    t_bk              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### rtl/ljpe_div.sv
// Pipelined restoring divider, one quotient bit per stage
module ljpe_div
    import ljpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_bk  i_item,
    output logic o_valid,
    output t_bk  o_item
);

    logic [DIV_STEPS-1:0] r_v;
    t_bk                  r_it [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= f_div_step(i_item);
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_it[s] <= f_div_step(r_it[s-1]);
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_item  = r_it[DIV_STEPS-1];

endmodule

### rtl/ljpe_term.sv
// 4eps*u*(u-1) term, cutoff term table, shift and clamp
module ljpe_term
    import ljpe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_bk  i_item,
    output logic o_valid,
    output t_out o_res
);

    localparam logic signed [TERM_W:0] E_HI = 65'sd2147483647;
    localparam logic signed [TERM_W:0] E_LO = -65'sd2147483648;

    typedef struct packed {
        logic              cal;
        logic [WIDX_W-1:0] widx;
        logic              shift;
        logic [P_W-1:0]    p;
        logic              zero;
        logic              far;
        logic              clip;
        logic              neg;
    } t_sd;

    logic [4:0] r_v;
    t_sd        r1_sd, r2_sd, r3_sd, r4_sd, r5_sd;
    logic [Q_W-1:0] r1_u, r1_d;
    logic [Q_W-1:0] r2_p00, r2_p01, r2_p10, r2_p11;
    logic [Q_W-1:0] r3_m;
    logic           r3_sat, r4_sat;
    logic [P_W+31:0] r4_pl, r4_ph;
    logic signed [TERM_W-1:0] r5_term;
    logic                     r5_rsat;
    logic signed [TERM_W-1:0] r_tc [NUM_WORDS];

    t_sd                      w_sd0;
    logic [2*Q_W-1:0]         w_prod;
    logic [P_W+Q_W-1:0]       w_x;
    logic [P_W+Q_W-29:0]      w_v;
    logic signed [TERM_W-1:0] w_term, w_tc;
    logic                     w_rsat;
    logic signed [TERM_W:0]   w_e;

    always_comb begin
        w_sd0.cal   = i_item.cal;
        w_sd0.widx  = i_item.widx;
        w_sd0.shift = i_item.shift;
        w_sd0.p     = i_item.p;
        w_sd0.zero  = i_item.zero;
        w_sd0.far   = i_item.far;
        w_sd0.clip  = i_item.clip;
        w_sd0.neg   = (i_item.lo[Q_W-1:32] == '0);
    end

    always_comb begin
        w_prod = {64'h0, r2_p00}
               + {32'h0, r2_p01, 32'h0}
               + {32'h0, r2_p10, 32'h0}
               + {r2_p11, 64'h0};
    end

    // P below 2^20 keeps the product below 2^84; only u*(u-1) and the divider can clip
    assign w_x = {r4_ph, 32'h0} + (P_W+Q_W)'(r4_pl);
    assign w_v = w_x[P_W+Q_W-1:28];

    always_comb begin
        w_rsat = 1'b0;
        if (r4_sd.p == '0) begin
            w_term = '0;
        end else if (r4_sd.clip) begin
            w_term = TERM_LIM;
            w_rsat = 1'b1;
        end else if (r4_sat) begin
            w_term = r4_sd.neg ? -TERM_LIM : TERM_LIM;
            w_rsat = 1'b1;
        end else begin
            w_term = r4_sd.neg ? -$signed(TERM_W'(w_v)) : $signed(TERM_W'(w_v));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_tc[i] <= '0;
            end
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
            // cutoff requests leave their term in the table
            if (r_v[4] && r5_sd.cal) begin
                r_tc[r5_sd.widx] <= r5_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sd   <= w_sd0;
            r1_u    <= i_item.lo;
            r1_d    <= w_sd0.neg ? (ONE_Q32 - i_item.lo) : (i_item.lo - ONE_Q32);
            r2_sd   <= r1_sd;
            r2_p00  <= Q_W'(r1_u[31:0])  * Q_W'(r1_d[31:0]);
            r2_p01  <= Q_W'(r1_u[31:0])  * Q_W'(r1_d[63:32]);
            r2_p10  <= Q_W'(r1_u[63:32]) * Q_W'(r1_d[31:0]);
            r2_p11  <= Q_W'(r1_u[63:32]) * Q_W'(r1_d[63:32]);
            r3_sd   <= r2_sd;
            r3_sat  <= (w_prod[127:96] != '0);
            r3_m    <= w_prod[95:32];
            r4_sd   <= r3_sd;
            r4_sat  <= r3_sat;
            r4_pl   <= (P_W+32)'(r3_sd.p) * (P_W+32)'(r3_m[31:0]);
            r4_ph   <= (P_W+32)'(r3_sd.p) * (P_W+32)'(r3_m[63:32]);
            r5_sd   <= r4_sd;
            r5_term <= w_term;
            r5_rsat <= w_rsat;
        end
    end

    assign w_tc = r_tc[r5_sd.widx];
    assign w_e  = {r5_term[TERM_W-1], r5_term}
                - (r5_sd.shift ? {w_tc[TERM_W-1], w_tc} : '0);

    always_comb begin
        o_res.saturated = 1'b0;
        if (r5_sd.far) begin
            o_res.pair_energy = '0;
        end else if (r5_sd.zero || r5_rsat) begin
            o_res.pair_energy = E_MAX;
            o_res.saturated   = 1'b1;
        end else if (w_e > E_HI) begin
            o_res.pair_energy = E_MAX;
            o_res.saturated   = 1'b1;
        end else if (w_e < E_LO) begin
            o_res.pair_energy = E_MIN;
            o_res.saturated   = 1'b1;
        end else begin
            o_res.pair_energy = w_e[31:0];
        end
    end

    assign o_valid = r_v[4] && !r5_sd.cal;

endmodule

### rtl/lj_pair_energy_cutoff_shift_unit.sv
// Lennard-Jones 12-6 pair energy with cutoff and shift, top level
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one separation vector,
// Q8.16 per component, and the two particle types per request.
// Output channel (o_out_valid / i_out_ready / o_out_data): pair energy in
// Q16.16 and a saturation flag, one result per request, in order.
// Config port: i_cfg_we writes i_cfg_data to pair word i_cfg_idx (0: types
// 0-0, 1: 0-1, 2: 1-1); other indices are ignored.
// Throughput: one request per cycle while the receiver keeps up and no config
// write is pending. Path from acceptance to o_out_valid: the distance front
// end, the three 64-stage divider pipelines (r^6 chain) and the five-stage
// multiply and clamp pipeline. Each config write recomputes the cutoff term of
// that pair word through the same pipeline, with o_in_ready low while pending.
// Reset clears all pair words to zero and empties every pipeline.
// When the receiver stalls, the whole back end holds; the front end fills a
// four-entry queue and then drops o_in_ready.
`include "lj_pair_energy_cutoff_shift_unit_assert.svh"

module lj_pair_energy_cutoff_shift_unit
    import ljpe_pkg::*;
#(
    parameter int NUM_TYPES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WIDX_W-1:0] i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data
);

    logic w_push, w_pop, w_empty, w_full, w_back_en;
    logic [$clog2(FIFO_DEPTH+1)-1:0] w_fifo_cnt;
    t_bk  w_front_item, w_head;
    logic w_d1_v, w_d2_v, w_d3_v, w_t_v;
    t_bk  w_d1_it, w_d2_it, w_d3_it;
    t_out w_res;

    logic r_p1_v, r_p2_v, r_out_valid;
    t_bk  r_p1, r_p2;
    t_out r_out;

    assign w_back_en = !r_out_valid || i_out_ready;
    assign w_pop     = w_back_en && !w_empty;

    ljpe_front #(
        .NUM_TYPES (NUM_TYPES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_push_ok  (!w_full),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    ljpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_fifo_cnt)
    );

    ljpe_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_back_en),
        .i_valid (w_pop),
        .i_item  (w_head),
        .o_valid (w_d1_v),
        .o_item  (w_d1_it)
    );

    ljpe_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_back_en),
        .i_valid (r_p1_v),
        .i_item  (r_p1),
        .o_valid (w_d2_v),
        .o_item  (w_d2_it)
    );

    ljpe_div u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_back_en),
        .i_valid (r_p2_v),
        .i_item  (r_p2),
        .o_valid (w_d3_v),
        .o_item  (w_d3_it)
    );

    ljpe_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_back_en),
        .i_valid (w_d3_v),
        .i_item  (w_d3_it),
        .o_valid (w_t_v),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_back_en) begin
            r_p1_v      <= w_d1_v;
            r_p2_v      <= w_d2_v;
            r_out_valid <= w_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_back_en) begin
            r_p1  <= f_prep(w_d1_it);
            r_p2  <= f_prep(w_d2_it);
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `LJPE_ASSERT_NEXT(a_cfg_blocks_input,
        i_cfg_we && (i_cfg_idx == CFG_FIRST_FIRST
            || i_cfg_idx == CFG_FIRST_SECOND
            || i_cfg_idx == CFG_SECOND_SECOND),
        !o_in_ready)
    `LJPE_ASSERT_NOW(a_sat_at_limit,
        o_out_valid && o_out_data.saturated,
        o_out_data.pair_energy == E_MAX || o_out_data.pair_energy == E_MIN)
    `LJPE_ASSERT_NEXT(a_stall_keeps_queue,
        !w_back_en,
        w_fifo_cnt >= $past(w_fifo_cnt))

endmodule
